// ----- rtl/dead_man_slew_limited_drive_command_core_assert.svh -----
// Assertion macros shared by the drive command core.
`ifndef DEAD_MAN_SLEW_LIMITED_DRIVE_COMMAND_CORE_ASSERT_SVH
`define DEAD_MAN_SLEW_LIMITED_DRIVE_COMMAND_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define DMSL_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define DMSL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dmsl_pkg.sv -----
// Types, constants and helper functions of the drive command core.
`default_nettype none

package dmsl_pkg;

   // configuration register widths and reset values
   localparam int STEER_ANGLE_W = 11;
   localparam int SPEED_MAX_W   = 13;
   localparam int RATE_W        = 16;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [STEER_ANGLE_W-1:0] STEER_ANGLE_RST = STEER_ANGLE_W'(524);
   localparam logic [SPEED_MAX_W-1:0]   SPEED_MAX_RST   = SPEED_MAX_W'(2000);
   localparam logic [RATE_W-1:0]        STEER_RATE_RST  = RATE_W'(1571);
   localparam logic [RATE_W-1:0]        ACCEL_RST       = RATE_W'(1000);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_STEER_ANGLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_SPEED       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_STEER_RATE  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ACCEL       = 2'd3;

   // beat kinds
   localparam logic CMD_JOYSTICK = 1'b0;
   localparam logic CMD_TICK     = 1'b1;
   localparam logic KIND_DRIVE   = 1'b0;
   localparam logic KIND_STOP    = 1'b1;

   // field widths
   localparam int AXIS_W  = 16;
   localparam int TICK_W  = 20;
   localparam int STEER_W = 12;
   localparam int SPEED_W = 14;

   // request tdata layout, lowest bit first
   localparam int REQ_DM_LSB    = 0;
   localparam int REQ_STEER_LSB = 1;
   localparam int REQ_SPEED_LSB = REQ_STEER_LSB + AXIS_W;
   localparam int REQ_TICK_LSB  = REQ_SPEED_LSB + AXIS_W;
   localparam int REQ_DATA_W    = ((REQ_TICK_LSB + TICK_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((STEER_W + SPEED_W + 7) / 8) * 8;

   // Q1.15 scaling: product plus half an LSB, floor by 2^15
   localparam int Q15_SHIFT     = 15;
   localparam int Q15_ROUND     = 16384;
   localparam int STEER_PROD_W  = AXIS_W + STEER_ANGLE_W + 2;
   localparam int SPEED_PROD_W  = AXIS_W + SPEED_MAX_W + 2;

   // slew step = floor((rate * dt + 500000) / 1e6), done as (n >> 6) / 15625
   localparam int                STEP_PROD_W = RATE_W + TICK_W;
   localparam logic [STEP_PROD_W-1:0] STEP_ROUND = STEP_PROD_W'(500000);
   localparam int                STEP_PRESHIFT = 6;
   localparam int                STEP_DIV_W    = STEP_PROD_W - STEP_PRESHIFT;
   localparam int                RECIP_SHIFT   = 45;
   localparam int                RECIP_W       = 32;
   localparam logic [63:0]       RECIP_WIDE    = ((64'd1 << RECIP_SHIFT) + 64'd15624) / 64'd15625;
   localparam logic [RECIP_W-1:0] RECIP_K      = RECIP_WIDE[RECIP_W-1:0];
   localparam int                RECIP_PROD_W  = STEP_DIV_W + RECIP_W;
   localparam int                STEP_W        = RECIP_PROD_W - RECIP_SHIFT;

   // working width of the slew compare
   localparam int SLEW_W = STEP_W + 2;

   // result queue depth
   localparam int RSP_FIFO_DEPTH = 8;

   typedef struct packed {
      logic                        kind;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [STEER_W-1:0]   steer;
   } rsp_item_type;

   // Move present toward target by at most step.
   function automatic logic signed [SLEW_W-1:0] slew_move(
      input logic signed [SLEW_W-1:0] target,
      input logic signed [SLEW_W-1:0] present,
      input logic        [STEP_W-1:0] step
   );
      logic signed [SLEW_W-1:0] s;
      logic signed [SLEW_W-1:0] moved;
      s = SLEW_W'(step);
      if (target > present) begin
         moved = present + s;
         slew_move = (moved < target) ? moved : target;
      end else begin
         moved = present - s;
         slew_move = (moved > target) ? moved : target;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dead_man_slew_limited_drive_command_core.sv -----
// Dead-man guarded, slew-rate limited drive command core (top level).
//
//  channel | dir | beat contents (lowest bit first)
//  --------+-----+-----------------------------------------------------------------
//  req_    | in  | tuser: cmd; tdata: dead_man_pressed, steer_axis, speed_axis, tick_us
//  rsp_    | out | tuser: kind; tdata: steer_out, speed_out
//  csr_    | in  | we, addr (0 angle, 1 speed, 2 steer rate, 3 accel), wdata
//
// One beat enters per cycle while req_tready is high. A beat passes the multiply stage
// (axis scaling, rate*dt), the reciprocal stage (divide by 1e6 via a 30x32 multiply),
// then the state update that slews the outputs and writes the result queue, from
// which it can leave on rsp_.
// Results wait in a FIFO_DEPTH-entry queue; req_tready is driven from a credit
// counter, so a stalled rsp_ side never backs up combinationally into req_.
// Reset (synchronous) clears state, pipeline valids, queue and registers to defaults.
`default_nettype none

module dead_man_slew_limited_drive_command_core
   import dmsl_pkg::*;
#(
   parameter int FIFO_DEPTH = RSP_FIFO_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // dead_man_pressed, steer_axis, speed_axis, tick_us
   input  wire logic                  req_tuser,  // cmd

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // steer_out, speed_out
   output logic                       rsp_tuser,  // kind

   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   `include "dead_man_slew_limited_drive_command_core_assert.svh"

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // ---------------------------------------------------------------- config
   logic [STEER_ANGLE_W-1:0] max_steer_ff;
   logic [SPEED_MAX_W-1:0]   max_speed_ff;
   logic [RATE_W-1:0]        steer_rate_ff;
   logic [RATE_W-1:0]        accel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_steer_ff  <= STEER_ANGLE_RST;
         max_speed_ff  <= SPEED_MAX_RST;
         steer_rate_ff <= STEER_RATE_RST;
         accel_ff      <= ACCEL_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_STEER_ANGLE: max_steer_ff  <= csr_wdata[STEER_ANGLE_W-1:0];
            CSR_MAX_SPEED:       max_speed_ff  <= csr_wdata[SPEED_MAX_W-1:0];
            CSR_MAX_STEER_RATE:  steer_rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_MAX_ACCEL:       accel_ff      <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- unpack
   logic                     req_accept;
   logic                     req_pressed;
   logic signed [AXIS_W-1:0] req_steer_axis;
   logic signed [AXIS_W-1:0] req_speed_axis;
   logic [TICK_W-1:0]        req_tick_us;

   assign req_accept     = req_tvalid && req_tready;
   assign req_pressed    = req_tdata[REQ_DM_LSB];
   assign req_steer_axis = req_tdata[REQ_STEER_LSB +: AXIS_W];
   assign req_speed_axis = req_tdata[REQ_SPEED_LSB +: AXIS_W];
   assign req_tick_us    = req_tdata[REQ_TICK_LSB +: TICK_W];

   // ---------------------------------------------------------------- stage 1: multiply
   logic                           s1_valid_ff;
   logic                           s1_cmd_ff;
   logic                           s1_pressed_ff;
   logic signed [STEER_PROD_W-1:0] s1_steer_prod_ff, s1_steer_prod_in;
   logic signed [SPEED_PROD_W-1:0] s1_speed_prod_ff, s1_speed_prod_in;
   logic [STEP_PROD_W-1:0]         s1_steer_n_ff, s1_steer_n_in;
   logic [STEP_PROD_W-1:0]         s1_speed_n_ff, s1_speed_n_in;

   // axis * full scale, plus half an LSB of the Q1.15 result
   assign s1_steer_prod_in = STEER_PROD_W'(req_steer_axis)
                           * STEER_PROD_W'($signed({1'b0, max_steer_ff}))
                           + STEER_PROD_W'(Q15_ROUND);
   assign s1_speed_prod_in = SPEED_PROD_W'(req_speed_axis)
                           * SPEED_PROD_W'($signed({1'b0, max_speed_ff}))
                           + SPEED_PROD_W'(Q15_ROUND);
   // rate * dt, plus half of one million
   assign s1_steer_n_in = STEP_PROD_W'(steer_rate_ff) * STEP_PROD_W'(req_tick_us) + STEP_ROUND;
   assign s1_speed_n_in = STEP_PROD_W'(accel_ff) * STEP_PROD_W'(req_tick_us) + STEP_ROUND;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff        <= req_tuser;
      s1_pressed_ff    <= req_pressed;
      s1_steer_prod_ff <= s1_steer_prod_in;
      s1_speed_prod_ff <= s1_speed_prod_in;
      s1_steer_n_ff    <= s1_steer_n_in;
      s1_speed_n_ff    <= s1_speed_n_in;
   end

   // ---------------------------------------------------------------- stage 2: reciprocal
   logic                      s2_valid_ff;
   logic                      s2_cmd_ff;
   logic                      s2_pressed_ff;
   logic signed [STEER_W-1:0] s2_des_steer_ff, s2_des_steer_in;
   logic signed [SPEED_W-1:0] s2_des_speed_ff, s2_des_speed_in;
   logic [STEP_W-1:0]         s2_steer_step_ff;
   logic [STEP_W-1:0]         s2_speed_step_ff;
   logic [RECIP_PROD_W-1:0]   steer_recip_prod;
   logic [RECIP_PROD_W-1:0]   speed_recip_prod;

   // floor by 2^15 is a plain bit select of the biased product
   assign s2_des_steer_in = s1_steer_prod_ff[Q15_SHIFT +: STEER_W];
   assign s2_des_speed_in = s1_speed_prod_ff[Q15_SHIFT +: SPEED_W];

   // (n >> 6) / 15625, exact by a rounded-up reciprocal
   assign steer_recip_prod = RECIP_PROD_W'(s1_steer_n_ff[STEP_PROD_W-1:STEP_PRESHIFT])
                           * RECIP_PROD_W'(RECIP_K);
   assign speed_recip_prod = RECIP_PROD_W'(s1_speed_n_ff[STEP_PROD_W-1:STEP_PRESHIFT])
                           * RECIP_PROD_W'(RECIP_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_cmd_ff        <= s1_cmd_ff;
      s2_pressed_ff    <= s1_pressed_ff;
      s2_des_steer_ff  <= s2_des_steer_in;
      s2_des_speed_ff  <= s2_des_speed_in;
      s2_steer_step_ff <= steer_recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
      s2_speed_step_ff <= speed_recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
   end

   // ---------------------------------------------------------------- stage 3: state update
   logic                      active_ff, active_in;
   logic signed [STEER_W-1:0] desired_steer_ff, desired_steer_in;
   logic signed [SPEED_W-1:0] desired_speed_ff, desired_speed_in;
   logic signed [STEER_W-1:0] last_steer_ff, last_steer_in;
   logic signed [SPEED_W-1:0] last_speed_ff, last_speed_in;
   logic signed [SLEW_W-1:0]  steer_slewed;
   logic signed [SLEW_W-1:0]  speed_slewed;
   logic                      push;
   logic                      drop;       // beat left the pipe without a result
   rsp_item_type              push_item;

   assign steer_slewed = slew_move(SLEW_W'(desired_steer_ff), SLEW_W'(last_steer_ff),
                                   s2_steer_step_ff);
   assign speed_slewed = slew_move(SLEW_W'(desired_speed_ff), SLEW_W'(last_speed_ff),
                                   s2_speed_step_ff);

   always_comb begin
      active_in        = active_ff;
      desired_steer_in = desired_steer_ff;
      desired_speed_in = desired_speed_ff;
      last_steer_in    = last_steer_ff;
      last_speed_in    = last_speed_ff;
      push             = 1'b0;
      push_item.kind   = KIND_DRIVE;
      push_item.steer  = last_steer_ff;
      push_item.speed  = last_speed_ff;
      if (s2_valid_ff) begin
         if (s2_cmd_ff == CMD_JOYSTICK) begin
            if (!s2_pressed_ff) begin
               // released: clear everything and send a stop
               active_in        = 1'b0;
               desired_steer_in = '0;
               desired_speed_in = '0;
               last_steer_in    = '0;
               last_speed_in    = '0;
               push             = 1'b1;
               push_item.kind   = KIND_STOP;
               push_item.steer  = '0;
               push_item.speed  = '0;
            end else begin
               // pressed: take new targets, no result
               active_in        = 1'b1;
               desired_steer_in = s2_des_steer_ff;
               desired_speed_in = s2_des_speed_ff;
            end
         end else if (active_ff) begin
            // tick: advance both outputs toward their targets
            last_steer_in   = steer_slewed[STEER_W-1:0];
            last_speed_in   = speed_slewed[SPEED_W-1:0];
            push            = 1'b1;
            push_item.kind  = KIND_DRIVE;
            push_item.steer = steer_slewed[STEER_W-1:0];
            push_item.speed = speed_slewed[SPEED_W-1:0];
         end
      end
   end

   assign drop = s2_valid_ff && !push;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         desired_steer_ff <= '0;
         desired_speed_ff <= '0;
         last_steer_ff    <= '0;
         last_speed_ff    <= '0;
      end else begin
         active_ff        <= active_in;
         desired_steer_ff <= desired_steer_in;
         desired_speed_ff <= desired_speed_in;
         last_steer_ff    <= last_steer_in;
         last_speed_ff    <= last_speed_in;
      end
   end

   // ---------------------------------------------------------------- result queue
   rsp_item_type             fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff;
   logic [PTR_W-1:0]         rd_ptr_ff;
   logic [CNT_W-1:0]         fifo_cnt_ff, fifo_cnt_in;
   logic [CNT_W-1:0]         credit_ff, credit_in;
   logic                     pop;
   rsp_item_type             head;

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tdata  = RSP_DATA_W'({head.speed, head.steer});
   assign pop        = rsp_tvalid && rsp_tready;

   // Every beat in flight holds a queue slot until it pops or drops out.
   assign req_tready = (credit_ff < CNT_FULL);

   assign fifo_cnt_in = fifo_cnt_ff + CNT_W'(push) - CNT_W'(pop);
   assign credit_in   = credit_ff + CNT_W'(req_accept) - CNT_W'(pop) - CNT_W'(drop);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         credit_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_in;
         credit_ff   <= credit_in;
      end
   end

   // ---------------------------------------------------------------- checks
   `DMSL_ASSERT_NOW(a_queue_within_credit, clock, reset, 1'b1,
                    fifo_cnt_ff <= credit_ff,
                    "queue holds more results than credits taken")
   `DMSL_ASSERT_NOW(a_credit_bound, clock, reset, 1'b1,
                    credit_ff <= CNT_FULL,
                    "credit counter overran the queue depth")
   `DMSL_ASSERT_NEXT(a_release_deactivates, clock, reset,
                     s2_valid_ff && (s2_cmd_ff == CMD_JOYSTICK) && !s2_pressed_ff,
                     !active_ff && (last_steer_ff == '0) && (last_speed_ff == '0),
                     "released dead-man left the drive active")
   `DMSL_ASSERT_NOW(a_stop_is_zero, clock, reset,
                    rsp_tvalid && (rsp_tuser == KIND_STOP),
                    rsp_tdata == '0,
                    "stop result carries nonzero drive")

endmodule

`default_nettype wire

// ----- dv/tb_dead_man_slew_limited_drive_command_core.sv -----
// Self-checking testbench for the dead-man guarded, slew-limited drive command core.
module tb_dead_man_slew_limited_drive_command_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dmsl_pkg::*;

   // Allow for ~1000 beats under heavy gaps and stalls, several times over.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   // Pipeline depth plus margin: a pressed joystick beat may still be in flight.
   localparam int          DRAIN_CYCLES = 10;

   // One request beat, unpacked into its fields.
   typedef struct {
      logic                     cmd;
      logic                     pressed;
      logic signed [AXIS_W-1:0] steer_axis;
      logic signed [AXIS_W-1:0] speed_axis;
      logic [TICK_W-1:0]        tick_us;
   } joy_beat_type;

   // Tracks the drive state, predicts commands and checks the rsp_ beats.
   class drive_cmd_tracker;
      logic [STEER_ANGLE_W-1:0]  steer_full;
      logic [SPEED_MAX_W-1:0]    speed_full;
      logic [RATE_W-1:0]         steer_rate;
      logic [RATE_W-1:0]         accel;
      logic                      engaged;
      logic signed [STEER_W-1:0] steer_goal;
      logic signed [STEER_W-1:0] steer_now;
      logic signed [SPEED_W-1:0] speed_goal;
      logic signed [SPEED_W-1:0] speed_now;
      rsp_item_type              pending_cmds[$];
      int                        mismatches;

      function new();
         steer_full = STEER_ANGLE_RST;
         speed_full = SPEED_MAX_RST;
         steer_rate = STEER_RATE_RST;
         accel      = ACCEL_RST;
         engaged    = 1'b0;
         steer_goal = '0;
         steer_now  = '0;
         speed_goal = '0;
         speed_now  = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_MAX_STEER_ANGLE: steer_full = value[STEER_ANGLE_W-1:0];
            CSR_MAX_SPEED:       speed_full = value[SPEED_MAX_W-1:0];
            CSR_MAX_STEER_RATE:  steer_rate = value[RATE_W-1:0];
            CSR_MAX_ACCEL:       accel      = value[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      // Q1.15 product, rounded to nearest with ties toward plus infinity.
      function longint scale_axis_q15(logic signed [AXIS_W-1:0] axis, longint full);
         return (longint'(axis) * full + 16384) >>> 15;
      endfunction

      // Move toward the goal by the rounded step rate*dt/1e6, never past it.
      function longint slew_toward(longint goal, longint now, longint rate, longint dt);
         longint step;
         step = (rate * dt + 500000) / 1000000;
         if (goal > now)
            return (now + step < goal) ? now + step : goal;
         return (now - step > goal) ? now - step : goal;
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= 10)
            $display("%s", what);
      endfunction

      function void accept_request(joy_beat_type b);
         rsp_item_type cmd;
         if (b.cmd == CMD_JOYSTICK) begin
            if (!b.pressed) begin
               engaged    = 1'b0;
               steer_goal = '0;
               steer_now  = '0;
               speed_goal = '0;
               speed_now  = '0;
               cmd.kind   = KIND_STOP;
               cmd.steer  = '0;
               cmd.speed  = '0;
               pending_cmds.push_back(cmd);
            end else begin
               engaged    = 1'b1;
               steer_goal = STEER_W'(scale_axis_q15(b.steer_axis, longint'(steer_full)));
               speed_goal = SPEED_W'(scale_axis_q15(b.speed_axis, longint'(speed_full)));
            end
         end else if (engaged) begin
            steer_now = STEER_W'(slew_toward(steer_goal, steer_now, steer_rate, b.tick_us));
            speed_now = SPEED_W'(slew_toward(speed_goal, speed_now, accel, b.tick_us));
            cmd.kind  = KIND_DRIVE;
            cmd.steer = steer_now;
            cmd.speed = speed_now;
            pending_cmds.push_back(cmd);
         end
      endfunction

      function void check_command(logic kind, logic [RSP_DATA_W-1:0] data);
         rsp_item_type              want;
         logic signed [STEER_W-1:0] steer_got;
         logic signed [SPEED_W-1:0] speed_got;
         steer_got = data[STEER_W-1:0];
         speed_got = data[STEER_W +: SPEED_W];
         if (pending_cmds.size() == 0) begin
            note_mismatch($sformatf("unexpected command: kind %0d steer %0d speed %0d",
                                    kind, steer_got, speed_got));
            return;
         end
         want = pending_cmds.pop_front();
         if (kind !== want.kind || steer_got !== want.steer || speed_got !== want.speed)
            note_mismatch($sformatf(
               "command mismatch: kind %0d/%0d steer %0d/%0d speed %0d/%0d (expected/actual)",
               want.kind, kind, want.steer, steer_got, want.speed, speed_got));
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire logic             req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // dead_man_pressed, steer_axis, speed_axis, tick_us
   logic                  req_tuser  = 1'b0; // cmd
   wire logic             rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   wire logic [RSP_DATA_W-1:0] rsp_tdata;    // steer_out, speed_out
   wire logic             rsp_tuser;         // kind
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   drive_cmd_tracker tracker;

   dead_man_slew_limited_drive_command_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stop a hung run.
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver stall pattern: rotate a 16-bit mask, reload it when rx_age reaches 63.
   // A reload is all ones a quarter of the time, or always when full rate is asked.
   logic [15:0] rx_pattern   = 16'hFFFF;
   int          rx_age       = 0;
   bit          rx_full_rate = 1'b0;
   always @(posedge clock) begin
      if (rx_age == 63) begin
         rx_age <= 0;
         if (rx_full_rate || $urandom_range(0, 3) == 0)
            rx_pattern <= '1;
         else
            rx_pattern <= 16'($urandom) | 16'h0001;
      end else begin
         rx_age     <= rx_age + 1;
         rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      end
      rsp_tready <= rx_pattern[0];
   end

   // Check every accepted result beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_command(rsp_tuser, rsp_tdata);
   end

   // Sender: bursts of random length, random gaps in between unless disabled.
   int burst_left = 0;
   bit tx_gaps    = 1'b1;

   task automatic send_beat(joy_beat_type b);
      if (burst_left == 0) begin
         if (tx_gaps) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.cmd;
      req_tdata  <= REQ_DATA_W'({b.tick_us, b.speed_axis, b.steer_axis, b.pressed});
      // hold the beat until the handshake completes
      do @(posedge clock); while (!req_tready);
      tracker.accept_request(b);
      burst_left--;
   endtask

   // Joystick beat; fill the unused tick field with noise.
   function automatic joy_beat_type joystick(bit pressed, int steer, int speed);
      joy_beat_type b;
      b.cmd        = CMD_JOYSTICK;
      b.pressed    = pressed;
      b.steer_axis = AXIS_W'(steer);
      b.speed_axis = AXIS_W'(speed);
      b.tick_us    = TICK_W'($urandom);
      return b;
   endfunction

   // Tick beat; fill the unused button and axes with noise.
   function automatic joy_beat_type tick(int unsigned dt);
      joy_beat_type b;
      b.cmd        = CMD_TICK;
      b.pressed    = 1'($urandom);
      b.steer_axis = AXIS_W'($urandom);
      b.speed_axis = AXIS_W'($urandom);
      b.tick_us    = TICK_W'(dt);
      return b;
   endfunction

   function automatic int random_axis();
      case ($urandom_range(0, 9))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         default: return int'($urandom);
      endcase
   endfunction

   // Mostly short intervals so slewing stays visible, with occasional long ones.
   function automatic int unsigned random_dt();
      case ($urandom_range(0, 9))
         0:             return 0;
         1, 2, 3, 4, 5: return $urandom_range(1, 2000);
         6, 7:          return $urandom_range(2000, 100000);
         8:             return $urandom_range(100000, 1048575);
         default:       return $urandom & 32'hFFFFF;
      endcase
   endfunction

   // Write all four registers on consecutive edges, then drop the enable.
   task automatic program_settings(logic [CSR_DATA_W-1:0] angle, logic [CSR_DATA_W-1:0] speed,
                                   logic [CSR_DATA_W-1:0] rate, logic [CSR_DATA_W-1:0] acc);
      logic [CSR_ADDR_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0] value [4];
      idx   = '{CSR_MAX_STEER_ANGLE, CSR_MAX_SPEED, CSR_MAX_STEER_RATE, CSR_MAX_ACCEL};
      value = '{angle, speed, rate, acc};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= value[i];
         @(posedge clock);
         tracker.set_register(idx[i], value[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait for every predicted command, then let the pipeline drain.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly press-then-ticks sequences with random content, some releases, some noise.
   task automatic run_random(int count);
      int           sent;
      int           ticks;
      joy_beat_type b;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 85) begin
            send_beat(joystick(1'b1, random_axis(), random_axis()));
            ticks = $urandom_range(1, 8);
            repeat (ticks) send_beat(tick(random_dt()));
            sent += ticks + 1;
            if ($urandom_range(0, 9) == 0) begin
               send_beat(joystick(1'b0, int'($urandom), int'($urandom)));
               sent++;
            end
         end else begin
            b.cmd        = 1'($urandom);
            b.pressed    = 1'($urandom);
            b.steer_axis = AXIS_W'($urandom);
            b.speed_axis = AXIS_W'($urandom);
            b.tick_us    = TICK_W'($urandom);
            send_beat(b);
            sent++;
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings.
      send_beat(tick(1000));                    // tick while inactive: no command
      send_beat(joystick(1'b1, 32767, -32768)); // full deflection, tick field ignored
      send_beat(tick(0));                       // zero interval: no movement
      send_beat(tick(1));                       // step rounds to zero
      send_beat(tick(500));                     // rounding tie on the speed step
      send_beat(tick(1048575));                 // longest interval: steer reaches its goal, speed does not
      send_beat(joystick(1'b1, -32768, 32767)); // opposite extremes
      send_beat(tick(250000));
      send_beat(tick(1048575));
      send_beat(joystick(1'b0, 12345, -2222));  // release: axes ignored, stop command
      send_beat(tick(5000));                    // inactive again
      send_beat(joystick(1'b1, 0, 0));          // press after release starts from zero
      send_beat(tick(1000));
      send_beat(joystick(1'b1, -1, 1));         // rounding near zero
      send_beat(joystick(1'b1, 16384, -16384)); // half deflection
      send_beat(tick(100000));
      send_beat(joystick(1'b0, 0, 0));
      send_beat(joystick(1'b0, -1, -1));        // second release in a row
      send_beat(joystick(1'b1, 12345, -12345));
      send_beat(tick(2000));
      send_beat(tick(2000));
      run_random(120);
      wait_idle();

      // Top of the stated ranges.
      program_settings(16'd1571, 16'd8000, 16'hFFFF, 16'hFFFF);
      run_random(130);
      wait_idle();

      // All zero: goals stay at zero and nothing moves.
      program_settings('0, '0, '0, '0);
      run_random(80);
      wait_idle();

      // Full register widths, every data bit set.
      program_settings('1, '1, '1, '1);
      run_random(130);
      wait_idle();

      // Slow slew, so most ticks stop short of the goal.
      program_settings(16'($urandom_range(0, 1571)), 16'($urandom_range(0, 8000)),
                       16'($urandom_range(1, 50)), 16'($urandom_range(1, 50)));
      run_random(130);
      wait_idle();

      // Back-to-back beats with the receiver always ready.
      tx_gaps      = 1'b0;
      rx_full_rate = 1'b1;
      program_settings(16'($urandom_range(0, 1571)), 16'($urandom_range(0, 8000)),
                       16'($urandom), 16'($urandom));
      run_random(130);
      wait_idle();
      tx_gaps      = 1'b1;
      rx_full_rate = 1'b0;

      // Random full-width settings.
      program_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_random(130);
      wait_idle();

      if (tracker.pending_cmds.size() != 0)
         tracker.note_mismatch($sformatf("%0d predicted commands never arrived",
                                         tracker.pending_cmds.size()));
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
